// ===== rtl/asterix_cat065_record_parser_defines.svh =====
// Assertion macros for the category 065 record parser checker.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef ASTERIX_CAT065_RECORD_PARSER_DEFINES_SVH
`define ASTERIX_CAT065_RECORD_PARSER_DEFINES_SVH

// same-cycle implication
`define AC65_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ac65 check failed");

// next-cycle implication
`define AC65_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ac65 check failed");

`endif

// ===== rtl/ac65_pkg.sv =====
// Types, constants and profile tables of the category 065 record parser.
// No dependencies.
package ac65_pkg;

  typedef enum logic [1:0] {
    PH_FSPEC1,
    PH_FSPEC2,
    PH_LEN,
    PH_DATA
  } phase_e;

  typedef enum logic [3:0] {
    KIND_SRC_ID   = 4'd0,
    KIND_MSG_TYPE = 4'd1,
    KIND_SERVICE  = 4'd2,
    KIND_TIME     = 4'd3,
    KIND_BATCH    = 4'd4,
    KIND_STATUS   = 4'd5,
    KIND_REPORT   = 4'd6,
    KIND_LAT      = 4'd7,
    KIND_LON      = 4'd8,
    KIND_REC_END  = 4'd9,
    KIND_ERROR    = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_FSPEC_LONG  = 3'd1,
    ERR_EMPTY       = 3'd2,
    ERR_UNASSIGNED  = 3'd3,
    ERR_ZERO_LEN    = 3'd4,
    ERR_TRUNCATED   = 3'd5,
    ERR_REF_SHORT   = 3'd6
  } err_e;

  localparam logic [3:0] FRN_STATUS     = 4'd6;
  localparam logic [3:0] FRN_LAST_FIXED = 4'd7;
  localparam logic [3:0] FRN_REF        = 4'd13;
  localparam logic [3:0] FRN_SPF        = 4'd14;

  localparam logic [1:0] ED_RESET     = 2'd1;
  localparam logic [1:0] ED_REF_POINT = 2'd2;

  localparam logic [7:0] REF_MIN_LEN       = 8'd2;
  localparam logic [7:0] REF_POINT_MIN_LEN = 8'd10;
  localparam logic [7:0] REF_FLAG_BYTE     = 8'd1;
  localparam logic [7:0] REF_LAT_BYTE      = 8'd5;
  localparam logic [7:0] REF_LON_BYTE      = 8'd9;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
    err_e               code;
  } result_t;

  // results caused by one byte; two set means res1 follows res0
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_buf_t;

  function automatic res_buf_t emit(res_buf_t b, kind_e k, logic [31:0] v, err_e c);
    res_buf_t o;
    o = b;
    if (b.cnt == 2'd0) begin
      o.r0  = '{kind: k, value: v, code: c};
      o.cnt = 2'd1;
    end else if (b.cnt == 2'd1) begin
      o.r1  = '{kind: k, value: v, code: c};
      o.cnt = 2'd2;
    end
    return o;
  endfunction

  // FSPEC octet bit 7 selects the lowest FRN of the octet
  function automatic logic [6:0] fspec_frns(logic [7:0] octet);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) begin
      r[i] = octet[7-i];
    end
    return r;
  endfunction

  function automatic logic [3:0] lowest_frn(logic [13:0] p);
    logic [3:0] f;
    f = '0;
    for (int i = 13; i >= 0; i--) begin
      if (p[i]) f = 4'(i + 1);
    end
    return f;
  endfunction

  function automatic logic [7:0] fixed_len(logic [3:0] frn);
    logic [7:0] l;
    unique case (frn)
      4'd1:                      l = 8'd2;
      4'd4:                      l = 8'd3;
      4'd2, 4'd3, 4'd5, 4'd6, 4'd7: l = 8'd1;
      default:                   l = 8'd0;
    endcase
    return l;
  endfunction

  function automatic kind_e kind_of(logic [3:0] frn);
    kind_e k;
    unique case (frn)
      4'd1:    k = KIND_SRC_ID;
      4'd2:    k = KIND_MSG_TYPE;
      4'd3:    k = KIND_SERVICE;
      4'd4:    k = KIND_TIME;
      4'd5:    k = KIND_BATCH;
      4'd6:    k = KIND_STATUS;
      default: k = KIND_REPORT;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/ac65_front.sv =====
// Byte parser: FSPEC, field walk and error handling, one byte per cycle while ac65_queue is not full.
// Depends on ac65_pkg; pushes the results of each byte into ac65_queue.
module ac65_front import ac65_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       block_last_i,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_data_i,
  input  logic       q_full_i,
  output push_t      push_o
);

  phase_e      phase_q, phase_d;
  logic [13:0] pend_q, pend_d;
  logic [3:0]  fref_q, fref_d;
  logic [7:0]  bif_q, bif_d;
  logic [7:0]  flen_q, flen_d;
  logic [31:0] acc_q, acc_d;
  logic        rpf_q, rpf_d;
  logic        disc_q, disc_d;
  logic [1:0]  ed_q;

  logic        accept;
  logic        ed2;
  logic [31:0] acc_sh;
  logic [7:0]  bif_inc;
  logic [3:0]  nf;
  logic        em_valid;
  kind_e       em_kind;
  logic [31:0] em_value;
  logic        raise;
  err_e        raise_code;
  logic        do_fin;
  logic        do_next;
  res_buf_t    rbuf;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ed2        = (ed_q == ED_REF_POINT);
  assign acc_sh     = {acc_q[23:0], data_byte_i};
  assign bif_inc    = bif_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    pend_d     = pend_q;
    fref_d     = fref_q;
    bif_d      = bif_q;
    flen_d     = flen_q;
    acc_d      = acc_q;
    rpf_d      = rpf_q;
    disc_d     = disc_q;
    em_valid   = 1'b0;
    em_kind    = KIND_REPORT;
    em_value   = '0;
    raise      = 1'b0;
    raise_code = ERR_NONE;
    do_fin     = 1'b0;
    do_next    = 1'b0;
    nf         = '0;
    rbuf       = '0;

    if (disc_q) begin
      if (block_last_i) begin
        disc_d  = 1'b0;
        phase_d = PH_FSPEC1;
      end
    end else begin
      unique case (phase_q)
        PH_FSPEC1: begin
          pend_d = {7'd0, fspec_frns(data_byte_i)};
          if (data_byte_i[0]) phase_d = PH_FSPEC2;
          else                do_fin  = 1'b1;
        end
        PH_FSPEC2: begin
          if (data_byte_i[0]) begin
            raise      = 1'b1;
            raise_code = ERR_FSPEC_LONG;
          end else begin
            pend_d[13:7] = fspec_frns(data_byte_i);
            do_fin       = 1'b1;
          end
        end
        PH_LEN: begin
          if (data_byte_i == 8'd0) begin
            raise      = 1'b1;
            raise_code = ERR_ZERO_LEN;
          end else if (ed2 && fref_q == FRN_REF && data_byte_i < REF_MIN_LEN) begin
            raise      = 1'b1;
            raise_code = ERR_REF_SHORT;
          end else begin
            flen_d = data_byte_i;
            bif_d  = 8'd1;
            if (data_byte_i == 8'd1) do_next = 1'b1;
            else                     phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          acc_d = acc_sh;
          bif_d = bif_inc;
          if (fref_q == FRN_REF && ed2) begin
            if (bif_q == REF_FLAG_BYTE) begin
              rpf_d = data_byte_i[7];
              if (data_byte_i[7] && flen_q < REF_POINT_MIN_LEN) begin
                raise      = 1'b1;
                raise_code = ERR_REF_SHORT;
              end
            end else if (bif_q == REF_LAT_BYTE && rpf_q) begin
              em_valid = 1'b1;
              em_kind  = KIND_LAT;
              em_value = acc_sh;
            end else if (bif_q == REF_LON_BYTE && rpf_q) begin
              em_valid = 1'b1;
              em_kind  = KIND_LON;
              em_value = acc_sh;
            end
          end
          if (!raise && bif_inc == flen_q) begin
            if (fref_q <= FRN_LAST_FIXED) begin
              em_valid = 1'b1;
              em_kind  = kind_of(fref_q);
              if (fref_q == FRN_STATUS) begin
                em_value = {26'd0, acc_sh[7:6], acc_sh[5], acc_sh[4], acc_sh[3:2]};
              end else begin
                em_value = acc_sh;
              end
            end
            do_next = 1'b1;
          end
        end
        default: ;
      endcase

      if (em_valid) rbuf = emit(rbuf, em_kind, em_value, ERR_NONE);

      if (do_fin) begin
        if (pend_d == '0) begin
          raise      = 1'b1;
          raise_code = ERR_EMPTY;
        end else begin
          do_next = 1'b1;
        end
      end

      if (do_next) begin
        if (pend_d == '0) begin
          rbuf    = emit(rbuf, KIND_REC_END, 32'd0, ERR_NONE);
          phase_d = PH_FSPEC1;
        end else begin
          nf                  = lowest_frn(pend_d);
          pend_d[nf - 4'd1]   = 1'b0;
          fref_d              = nf;
          acc_d               = '0;
          bif_d               = '0;
          rpf_d               = 1'b0;
          if (nf == FRN_REF || nf == FRN_SPF) begin
            phase_d = PH_LEN;
          end else if (fixed_len(nf) == 8'd0) begin
            raise      = 1'b1;
            raise_code = ERR_UNASSIGNED;
          end else begin
            flen_d  = fixed_len(nf);
            phase_d = PH_DATA;
          end
        end
      end

      // block ends inside an FSPEC or a record
      if (!raise && block_last_i && phase_d != PH_FSPEC1) begin
        raise      = 1'b1;
        raise_code = ERR_TRUNCATED;
      end

      if (raise) begin
        rbuf    = emit(rbuf, KIND_ERROR, 32'd0, raise_code);
        phase_d = PH_FSPEC1;
        pend_d  = '0;
        disc_d  = !block_last_i;
      end

      if (block_last_i) begin
        disc_d  = 1'b0;
        phase_d = PH_FSPEC1;
      end
    end
  end

  assign push_o.valid      = accept && (rbuf.cnt != 2'd0);
  assign push_o.entry.two  = (rbuf.cnt == 2'd2);
  assign push_o.entry.res0 = rbuf.r0;
  assign push_o.entry.res1 = rbuf.r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FSPEC1;
      pend_q  <= '0;
      fref_q  <= '0;
      bif_q   <= '0;
      flen_q  <= '0;
      acc_q   <= '0;
      rpf_q   <= 1'b0;
      disc_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      fref_q  <= fref_d;
      bif_q   <= bif_d;
      flen_q  <= flen_d;
      acc_q   <= acc_d;
      rpf_q   <= rpf_d;
      disc_q  <= disc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ed_q <= ED_RESET;
    end else if (cfg_valid_i) begin
      ed_q <= cfg_data_i;
    end
  end

endmodule

// ===== rtl/ac65_queue.sv =====
// Small register FIFO of per-byte result entries between parser and output.
// Depends on ac65_pkg.
module ac65_queue import ac65_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t entry_o,
  input  logic   pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// ===== rtl/ac65_back.sv =====
// Output stage: takes queue entries and delivers their results one per transfer.
// Depends on ac65_pkg.
module ac65_back import ac65_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  entry_t             q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic [2:0]         error_code_o,
  output logic               result_last_o
);

  entry_t  ent_q;
  logic    hold_q;
  logic    idx_q;
  result_t cur;
  logic    take, load;

  assign cur           = idx_q ? ent_q.res1 : ent_q.res0;
  assign out_valid_o   = hold_q;
  assign kind_o        = cur.kind;
  assign value_o       = cur.value;
  assign error_code_o  = cur.code;
  assign result_last_o = idx_q || !ent_q.two;

  assign take    = out_valid_o && out_ready_i;
  assign load    = !hold_q || (take && result_last_o);
  assign q_pop_o = load && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) ent_q <= q_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      idx_q  <= 1'b0;
    end else if (load) begin
      hold_q <= q_valid_i;
      idx_q  <= 1'b0;
    end else if (take) begin
      idx_q  <= 1'b1;
    end
  end

endmodule

// ===== rtl/asterix_cat065_record_parser.sv =====
// Category 065 record parser: one byte per cycle in, one result per cycle out, while neither side is stalled.
// out_valid_o rises once the result has passed through the entry queue and the output stage register.
// A byte that causes two results holds the output for two transfers; the entry queue
// (QueueDepth entries) absorbs short runs of these, sustained ones fill it and hold off input.
// Reset (rst_ni low, asynchronous) puts the parser at the first FSPEC octet,
// sets edition to 1 and empties the queue and output stage.
module asterix_cat065_record_parser import ac65_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               block_last_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic [2:0]         error_code_o,
  output logic               result_last_o
);

  push_t  push;
  logic   q_full;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  assign cfg_ready_o = 1'b1;

  ac65_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .block_last_i (block_last_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  ac65_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  ac65_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .error_code_o  (error_code_o),
    .result_last_o (result_last_o)
  );

endmodule

// ===== rtl/ac65_checker.sv =====
// Port-level checks on the result channel of the category 065 record parser.
// Depends on ac65_pkg and the defines header; bound to the top level below.
`include "asterix_cat065_record_parser_defines.svh"

module ac65_checker import ac65_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [3:0]         kind_o,
  input logic signed [31:0] value_o,
  input logic [2:0]         error_code_o,
  input logic               result_last_o
);

  logic        marker;
  logic        stall;
  logic [39:0] payload;
  assign marker  = out_valid_o && (kind_o == KIND_REC_END || kind_o == KIND_ERROR);
  assign stall   = out_valid_o && !out_ready_i;
  assign payload = {kind_o, value_o, error_code_o, result_last_o};

  `AC65_ASSERT_NXT(a_out_hold, stall, out_valid_o && $stable(payload))
  `AC65_ASSERT_IMP(a_code_kind, out_valid_o, (kind_o == KIND_ERROR) == (error_code_o != ERR_NONE))
  `AC65_ASSERT_IMP(a_marker_zero, marker, value_o == 32'sd0)
  `AC65_ASSERT_IMP(a_marker_last, marker, result_last_o)

endmodule

bind asterix_cat065_record_parser ac65_checker u_ac65_checker (.*);

// ===== test/asterix_cat065_record_parser_tb.sv =====
// Testbench for asterix_cat065_record_parser: byte stream in, decoded fields out.
// Uses ac65_pkg for kinds, error codes and profile constants; a built-in decoder
// predicts every result, which is checked in order under random idle and stall.
module asterix_cat065_record_parser_tb;
  import ac65_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [31:0] value;
    err_e        code;
    logic        is_last;
  } field_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        block_last_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  kind_o;
  logic signed [31:0] value_o;
  logic [2:0]  error_code_o;
  logic        result_last_o;

  asterix_cat065_record_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .block_last_i  (block_last_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .error_code_o  (error_code_o),
    .result_last_o (result_last_o)
  );

  always #10 clk_i = ~clk_i;

  field_result_t expected_fields[$];
  field_result_t byte_fields[$];
  logic [7:0]    block_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int n_errors = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_ref_points = 0;
  int n_error_reports = 0;

  // decoder state mirror
  logic [1:0]  edition_m = ED_RESET;
  phase_e      phase_m = PH_FSPEC1;
  logic [13:0] pending_m = '0;
  logic [3:0]  frn_m = '0;
  logic [7:0]  pos_m = '0;
  logic [7:0]  len_m = '0;
  logic [31:0] acc_m = '0;
  logic        refpt_m = 1'b0;
  logic        skip_m = 1'b0;
  logic        blk_last_m = 1'b0;
  logic        err_m = 1'b0;

  function automatic logic [7:0] profile_len(logic [3:0] frn);
    case (frn)
      4'd1:                         return 8'd2;
      4'd4:                         return 8'd3;
      4'd2, 4'd3, 4'd5, 4'd6, 4'd7: return 8'd1;
      default:                      return 8'd0;
    endcase
  endfunction

  function automatic logic [31:0] status_word(logic [7:0] s);
    return {26'd0, s[7:6], s[5], s[4], s[3:2]};
  endfunction

  function automatic void add_result(kind_e k, logic [31:0] v, err_e c);
    field_result_t r;
    if (byte_fields.size() < 2) begin
      r.kind = k;
      r.value = v;
      r.code = c;
      r.is_last = 1'b0;
      byte_fields.push_back(r);
    end
  endfunction

  function automatic void flag_error(err_e c);
    add_result(KIND_ERROR, 32'd0, c);
    err_m = 1'b1;
    phase_m = PH_FSPEC1;
    pending_m = '0;
    skip_m = !blk_last_m;
  endfunction

  function automatic void advance_field();
    int f;
    int lowest;
    if (pending_m == '0) begin
      add_result(KIND_REC_END, 32'd0, ERR_NONE);
      phase_m = PH_FSPEC1;
      return;
    end
    lowest = 0;
    for (f = 14; f >= 1; f--) begin
      if (pending_m[f-1]) lowest = f;
    end
    pending_m[lowest-1] = 1'b0;
    frn_m = 4'(lowest);
    acc_m = '0;
    pos_m = '0;
    refpt_m = 1'b0;
    if (frn_m == FRN_REF || frn_m == FRN_SPF) begin
      phase_m = PH_LEN;
    end else if (profile_len(frn_m) == 8'd0) begin
      flag_error(ERR_UNASSIGNED);
    end else begin
      len_m = profile_len(frn_m);
      phase_m = PH_DATA;
    end
  endfunction

  function automatic void close_fspec();
    if (pending_m == '0) flag_error(ERR_EMPTY);
    else advance_field();
  endfunction

  // predicts the results of one accepted byte and queues them
  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    int i;
    logic [7:0] pos_was;
    logic ref_abort;
    byte_fields.delete();
    blk_last_m = is_last;
    err_m = 1'b0;
    ref_abort = 1'b0;
    if (skip_m) begin
      if (is_last) begin
        skip_m = 1'b0;
        phase_m = PH_FSPEC1;
      end
      return;
    end
    case (phase_m)
      PH_FSPEC1: begin
        pending_m = '0;
        for (i = 0; i < 7; i++) pending_m[i] = b[7-i];
        if (b[0]) phase_m = PH_FSPEC2;
        else close_fspec();
      end
      PH_FSPEC2: begin
        if (b[0]) begin
          flag_error(ERR_FSPEC_LONG);
        end else begin
          for (i = 0; i < 7; i++) pending_m[7+i] = b[7-i];
          close_fspec();
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          flag_error(ERR_ZERO_LEN);
        end else if (edition_m == ED_REF_POINT && frn_m == FRN_REF && b < REF_MIN_LEN) begin
          flag_error(ERR_REF_SHORT);
        end else begin
          len_m = b;
          pos_m = 8'd1;
          if (b == 8'd1) advance_field();
          else phase_m = PH_DATA;
        end
      end
      default: begin
        pos_was = pos_m;
        acc_m = {acc_m[23:0], b};
        pos_m = pos_m + 8'd1;
        if (frn_m == FRN_REF && edition_m == ED_REF_POINT) begin
          if (pos_was == REF_FLAG_BYTE) begin
            refpt_m = b[7];
            if (refpt_m && len_m < REF_POINT_MIN_LEN) begin
              flag_error(ERR_REF_SHORT);
              ref_abort = 1'b1;
            end
          end else if (pos_was == REF_LAT_BYTE && refpt_m) begin
            add_result(KIND_LAT, acc_m, ERR_NONE);
          end else if (pos_was == REF_LON_BYTE && refpt_m) begin
            add_result(KIND_LON, acc_m, ERR_NONE);
          end
        end
        if (!ref_abort && pos_m == len_m) begin
          if (frn_m <= FRN_LAST_FIXED)
            add_result(kind_e'(frn_m - 4'd1),
                       (frn_m == FRN_STATUS) ? status_word(acc_m[7:0]) : acc_m, ERR_NONE);
          advance_field();
        end
      end
    endcase
    if (is_last && !err_m && phase_m != PH_FSPEC1) flag_error(ERR_TRUNCATED);
    if (is_last) begin
      skip_m = 1'b0;
      phase_m = PH_FSPEC1;
    end
    if (byte_fields.size() > 0) byte_fields[byte_fields.size()-1].is_last = 1'b1;
    foreach (byte_fields[k]) expected_fields.push_back(byte_fields[k]);
  endtask

  // ---------------- driving ----------------

  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    block_last_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_byte(b, is_last);
    n_bytes++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_block();
    int k;
    for (k = 0; k < block_q.size(); k++) send_byte(block_q[k], k == block_q.size() - 1);
  endtask

  // sender holds off until every predicted result has been seen
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_edition(input logic [1:0] ed);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= ed;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    edition_m = ed;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------- checking ----------------

  function automatic void compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    field_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (kind_o == KIND_LAT) n_ref_points++;
      if (kind_o == KIND_ERROR) n_error_reports++;
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d value %0h code %0d",
                 $time, kind_o, value_o, error_code_o);
        n_errors++;
      end else begin
        want = expected_fields.pop_front();
        compare_field("kind", kind_o, want.kind);
        compare_field("value", value_o, want.value);
        compare_field("error_code", error_code_o, want.code);
        compare_field("result_last", result_last_o, want.is_last);
      end
    end
  end

  // ---------------- record builders ----------------

  function automatic void add_fixed_fields(logic [7:0] fs1);
    int f;
    int k;
    for (f = 1; f <= 7; f++) begin
      if (fs1[8-f]) begin
        for (k = 0; k < profile_len(4'(f)); k++) block_q.push_back(8'($urandom_range(255)));
      end
    end
  endfunction

  function automatic void add_good_record(logic [1:0] ed);
    logic [7:0] fs1;
    logic [7:0] len;
    logic want_ref;
    logic want_spf;
    logic rp;
    int k;
    fs1 = 8'($urandom_range(255)) & 8'hFE;
    want_ref = ($urandom_range(3) == 0);
    want_spf = ($urandom_range(5) == 0);
    if (fs1 == 8'h00 && !want_ref && !want_spf) fs1 = 8'h80 >> $urandom_range(6);
    if (want_ref || want_spf) begin
      block_q.push_back(fs1 | 8'h01);
      block_q.push_back({5'b0, want_ref, want_spf, 1'b0});
    end else begin
      block_q.push_back(fs1);
    end
    add_fixed_fields(fs1);
    if (want_ref) begin
      rp = (ed == ED_REF_POINT) && ($urandom_range(1) == 1);
      if (rp) len = 8'($urandom_range(14, 10));
      else len = 8'($urandom_range(6, (ed == ED_REF_POINT) ? 2 : 1));
      block_q.push_back(len);
      for (k = 1; k < len; k++) begin
        if (k == 1 && ed == ED_REF_POINT) block_q.push_back({rp, 7'($urandom_range(127))});
        else block_q.push_back(8'($urandom_range(255)));
      end
    end
    if (want_spf) begin
      // now and then a long one so the byte position runs high
      len = ($urandom_range(60) == 0) ? 8'($urandom_range(255, 200)) : 8'($urandom_range(5, 1));
      block_q.push_back(len);
      for (k = 1; k < len; k++) block_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void add_bad_record();
    logic [7:0] fs1;
    int k;
    case ($urandom_range(5))
      0: begin
        if ($urandom_range(1)) block_q.push_back(8'h00);
        else begin
          block_q.push_back(8'h01);
          block_q.push_back(8'h00);
        end
      end
      1: begin
        block_q.push_back(8'($urandom_range(255)) | 8'h01);
        block_q.push_back(8'($urandom_range(255)) | 8'h01);
      end
      2: begin
        fs1 = 8'($urandom_range(255)) & 8'hFE;
        block_q.push_back(fs1 | 8'h01);
        block_q.push_back(8'h80 >> $urandom_range(4));
        add_fixed_fields(fs1);
      end
      3: begin
        block_q.push_back(8'h01);
        block_q.push_back($urandom_range(1) ? 8'h04 : 8'h02);
        block_q.push_back(8'h00);
      end
      4: begin
        block_q.push_back(8'h01);
        block_q.push_back(8'h04);
        if ($urandom_range(1)) block_q.push_back(8'h01);
        else begin
          block_q.push_back(8'($urandom_range(9, 2)));
          block_q.push_back(8'h80 | 8'($urandom_range(127)));
        end
      end
      default: begin
        for (k = 0; k < $urandom_range(6, 1); k++) block_q.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  task automatic send_random_block();
    int r;
    int cut;
    block_q.delete();
    for (r = 0; r < $urandom_range(4, 1); r++) begin
      if ($urandom_range(9) == 0) add_bad_record();
      else add_good_record(edition_m);
    end
    if ($urandom_range(7) == 0 && block_q.size() > 1) begin
      cut = $urandom_range(block_q.size() - 1, 1);
      repeat (cut) void'(block_q.pop_back());
    end
    send_block();
  endtask

  // ---------------- tests ----------------

  task automatic test_fixed_fields();
    // every fixed field, with values at both ends
    block_q = '{8'hFE, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h00, 8'hFF, 8'h55, 8'hAA};
    send_block();
  endtask

  task automatic test_error_cases();
    block_q = '{8'h00};
    send_block();
    block_q = '{8'h01, 8'h03};
    send_block();
    block_q = '{8'h01, 8'h80};
    send_block();
    block_q = '{8'h01, 8'h02, 8'h00};
    send_block();
    // block ends inside the source id
    block_q = '{8'h80, 8'h12};
    send_block();
  endtask

  task automatic test_ref_point();
    wait_quiet();
    write_edition(ED_REF_POINT);
    // lat at the negative end, lon at the positive end
    block_q = '{8'h01, 8'h04, 8'h0A, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00,
                8'h7F, 8'hFF, 8'hFF, 8'hFF};
    send_block();
    block_q = '{8'h01, 8'h04, 8'h01};
    send_block();
  endtask

  task automatic test_random_traffic();
    logic [1:0]  ed_plan[8];
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    int s;
    int start;
    ed_plan = '{2'd0, ED_REF_POINT, 2'd3, ED_REF_POINT, ED_RESET, ED_REF_POINT, 2'd3,
                ED_REF_POINT};
    idle_plan = '{0, 84, 0, 27};
    stall_plan = '{0, 0, 84, 27};
    for (s = 0; s < 8; s++) begin
      wait_quiet();
      write_edition(ed_plan[s]);
      send_idle_pct = idle_plan[s/2];
      stall_pct = stall_plan[s/2];
      start = n_bytes;
      while (n_bytes - start < 100) send_random_block();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fixed_fields();
    test_error_cases();
    test_ref_point();
    test_random_traffic();
    wait_quiet();
    $display("covered %0d bytes, %0d results checked (%0d error reports, %0d ref points)",
             n_bytes, n_results, n_error_reports, n_ref_points);
    $display("editions 0..3 written; idle/stall mixes none, sender, receiver, both");
    if (n_errors == 0) begin
      $display("asterix_cat065_record_parser_tb: done, clean");
    end else begin
      $display("asterix_cat065_record_parser_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_fields.size());
    $display("asterix_cat065_record_parser_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ac65_pkg.sv
rtl/ac65_front.sv
rtl/ac65_queue.sv
rtl/ac65_back.sv
rtl/asterix_cat065_record_parser.sv
rtl/ac65_checker.sv
test/asterix_cat065_record_parser_tb.sv
